FILE: sv/wdrr_pkg.sv
`default_nettype none

package wdrr_pkg;

  // default sizes
  localparam int unsigned NUM_QUEUES_DEF   = 4;
  localparam int unsigned FIFO_DEPTH_DEF   = 16;

  // field and register widths
  localparam int unsigned LEN_W            = 16;
  localparam int unsigned GQ_W             = 2;
  localparam int unsigned QIDX_W           = 2;
  localparam int unsigned QUANTUM_W        = 24;
  localparam int unsigned DEFICIT_W        = 32;
  localparam int unsigned FRAC_SHIFT       = 8;
  localparam int unsigned NUM_QUANTUM_REGS = 4;
  localparam int unsigned CFG_IDX_W        = 2;

  // 500 bytes in 1/256 byte units
  localparam int unsigned DEFAULT_QUANTUM_BYTES = 500;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET =
    QUANTUM_W'(DEFAULT_QUANTUM_BYTES << FRAC_SHIFT);

  // action codes
  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  typedef struct packed {
    logic              action;
    logic [QIDX_W-1:0] queue_index;
    logic [LEN_W-1:0]  packet_length;
  } in_item_t;

  typedef struct packed {
    logic             granted;
    logic [GQ_W-1:0]  grant_queue;
    logic [LEN_W-1:0] grant_length;
    logic             enqueue_dropped;
    logic             backlog_seen;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_CREDIT,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

FILE: sv/wdrr_ram.sv
`default_nettype none

module wdrr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/weighted_drr_scheduler.sv
`default_nettype none

// channel   direction  handshake                payload
// in        input      in_valid_i / in_ready_o  in_data_i  (in_item_t)
// out       output     out_valid_o / out_ready_i out_data_o (out_item_t)
// cfg       input      cfg_we_i (no wait)       cfg_index_i, cfg_data_i
//
// one transaction at a time; in_ready_o is high only in the idle state
// a dequeue visits queues round-robin from the current one; each visit is
//   a length-store read, a compare/subtract and, unless it grants, a credit
//   add to the next queue; the last two share one 33-bit add/sub unit
// the finished result sits in an output register, so an output stall only
//   holds the block once a second result is ready
// asynchronous active-low reset clears deficits, fifo pointers and counts;
//   quanta return to 500 bytes; the length store is not cleared

module weighted_drr_scheduler
  import wdrr_pkg::*;
#(
  parameter int unsigned NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_item_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_item_t                 out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [QUANTUM_W-1:0] cfg_data_i
);

  localparam int unsigned QW     = $clog2(NUM_QUEUES);
  localparam int unsigned VW     = $clog2(NUM_QUEUES);
  localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned RAM_AW = QW + PTR_W;
  localparam int unsigned RAM_DEPTH = NUM_QUEUES << PTR_W;
  localparam int unsigned SUM_W  = DEFICIT_W + 1;

  // control state
  state_e              state_q, state_d;
  logic [QW-1:0]       next_q_q, next_q_d;     // queue the scheduler points at
  logic [VW-1:0]       visit_q, visit_d;       // visits done in this dequeue
  logic [PTR_W-1:0]    rptr_q [NUM_QUEUES];
  logic [PTR_W-1:0]    rptr_d [NUM_QUEUES];
  logic [PTR_W-1:0]    wptr_q [NUM_QUEUES];
  logic [PTR_W-1:0]    wptr_d [NUM_QUEUES];
  logic [CNT_W-1:0]    cnt_q  [NUM_QUEUES];
  logic [CNT_W-1:0]    cnt_d  [NUM_QUEUES];
  logic [DEFICIT_W-1:0] deficit_q [NUM_QUEUES];
  logic [DEFICIT_W-1:0] deficit_d [NUM_QUEUES];
  logic [QUANTUM_W-1:0] quantum_q [NUM_QUANTUM_REGS];
  logic [QUANTUM_W-1:0] quantum_d [NUM_QUANTUM_REGS];
  logic                out_valid_q, out_valid_d;

  // payload
  out_item_t           res_q, res_d;
  out_item_t           out_q, out_d;

  // handshakes
  logic in_fire;
  logic out_free;

  // enqueue decode
  logic          enq_oor;
  logic [QW-1:0] enq_sel;
  logic          enq_drop;

  // length store
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic [LEN_W-1:0]  ram_rdata;

  // shared add/sub unit
  logic [QW-1:0]    nq;
  logic             unit_credit;
  logic [QW-1:0]    unit_idx;
  logic [SUM_W-1:0] unit_a;
  logic [SUM_W-1:0] unit_b;
  logic [SUM_W-1:0] unit_sum;
  logic             head_empty;
  logic             grant_hit;
  logic             last_visit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an out-of-range queue only exists when there are fewer than four queues
  assign enq_oor  = (32'(in_data_i.queue_index) >= NUM_QUEUES);
  assign enq_sel  = enq_oor ? '0 : QW'(in_data_i.queue_index);
  assign enq_drop = enq_oor | (cnt_q[enq_sel] >= CNT_W'(FIFO_DEPTH));

  assign ram_waddr = {enq_sel, wptr_q[enq_sel]};
  assign ram_raddr = {next_q_q, rptr_q[next_q_q]};
  assign ram_re    = (state_q == ST_READ);

  wdrr_ram #(
    .WIDTH (LEN_W),
    .DEPTH (RAM_DEPTH)
  ) u_len_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_data_i.packet_length),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // round-robin successor of the current queue
  assign nq = (next_q_q == QW'(NUM_QUEUES - 1)) ? '0 : next_q_q + 1'b1;

  // check: deficit minus head length (borrow means it does not fit)
  // credit: next deficit plus its quantum (carry means saturate)
  assign unit_credit = (state_q == ST_CREDIT);
  assign unit_idx    = unit_credit ? nq : next_q_q;
  assign unit_a      = {1'b0, deficit_q[unit_idx]};
  assign unit_b      = unit_credit ? SUM_W'(quantum_q[2'(nq)])
                                   : SUM_W'({ram_rdata, {FRAC_SHIFT{1'b0}}});
  assign unit_sum    = unit_credit ? (unit_a + unit_b) : (unit_a - unit_b);

  assign head_empty = (cnt_q[next_q_q] == '0);
  assign grant_hit  = ~head_empty & ~unit_sum[DEFICIT_W];
  assign last_visit = (visit_q == VW'(NUM_QUEUES - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_data_i.action == ACT_DEQUEUE) ? ST_READ : ST_FINISH;
        end
      end
      ST_READ:   state_d = ST_CHECK;
      ST_CHECK:  state_d = grant_hit ? ST_FINISH : ST_CREDIT;
      ST_CREDIT: state_d = last_visit ? ST_FINISH : ST_READ;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    next_q_d    = next_q_q;
    visit_d     = visit_q;
    rptr_d      = rptr_q;
    wptr_d      = wptr_q;
    cnt_d       = cnt_q;
    deficit_d   = deficit_q;
    quantum_d   = quantum_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_d   = '0;
          visit_d = '0;
          if (in_data_i.action == ACT_ENQUEUE) begin
            if (enq_drop) begin
              res_d.enqueue_dropped = 1'b1;
            end else begin
              ram_we          = 1'b1;
              wptr_d[enq_sel] = (wptr_q[enq_sel] == PTR_W'(FIFO_DEPTH - 1))
                                ? '0 : wptr_q[enq_sel] + 1'b1;
              cnt_d[enq_sel]  = cnt_q[enq_sel] + 1'b1;
            end
          end
        end
      end
      ST_READ: begin
      end
      ST_CHECK: begin
        if (head_empty) begin
          deficit_d[next_q_q] = '0;
        end else begin
          res_d.backlog_seen = 1'b1;
          if (grant_hit) begin
            deficit_d[next_q_q] = unit_sum[DEFICIT_W-1:0];
            rptr_d[next_q_q]    = (rptr_q[next_q_q] == PTR_W'(FIFO_DEPTH - 1))
                                  ? '0 : rptr_q[next_q_q] + 1'b1;
            cnt_d[next_q_q]     = cnt_q[next_q_q] - 1'b1;
            res_d.granted       = 1'b1;
            res_d.grant_queue   = GQ_W'(next_q_q);
            res_d.grant_length  = ram_rdata;
          end
        end
      end
      ST_CREDIT: begin
        deficit_d[nq] = unit_sum[DEFICIT_W] ? '1 : unit_sum[DEFICIT_W-1:0];
        next_q_d      = nq;
        visit_d       = visit_q + 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (cfg_we_i) begin
      quantum_d[cfg_index_i] = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_q_q    <= '0;
      visit_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rptr_q[i]    <= '0;
        wptr_q[i]    <= '0;
        cnt_q[i]     <= '0;
        deficit_q[i] <= '0;
      end
      for (int i = 0; i < NUM_QUANTUM_REGS; i++) begin
        quantum_q[i] <= QUANTUM_RESET;
      end
    end else begin
      state_q     <= state_d;
      next_q_q    <= next_q_d;
      visit_q     <= visit_d;
      out_valid_q <= out_valid_d;
      rptr_q      <= rptr_d;
      wptr_q      <= wptr_d;
      cnt_q       <= cnt_d;
      deficit_q   <= deficit_d;
      quantum_q   <= quantum_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import wdrr_pkg::*;

  localparam int unsigned NUM_Q       = NUM_QUEUES_DEF;
  localparam int unsigned DEPTH       = FIFO_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_SHOWN   = 10;
  // longest dequeue walk plus a little slack
  localparam int unsigned DRAIN_CYCLES = 3 * NUM_Q + 6;

  // quantum register indexes
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_Q0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_Q1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_Q2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_Q3 = CFG_IDX_W'(3);

  localparam logic [QUANTUM_W-1:0] QUANTUM_MAX = '1;

  // every input known from time zero
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  in_item_t             in_data_i   = '0;
  logic                 out_ready_i = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [QUANTUM_W-1:0] cfg_data_i  = '0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  out_item_t            out_data_o;

  weighted_drr_scheduler uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // items waiting to be offered, and the scheduler decisions still owed
  in_item_t  pending_items[$];
  out_item_t owed_decisions[$];

  // idle percentages for the two sides, changed between phases
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 59;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // shadow of the scheduler: length fifos, deficits, round-robin cursor
  logic [LEN_W-1:0]     len_mem [NUM_Q][DEPTH];
  int unsigned          rd_ptr [NUM_Q];
  int unsigned          wr_ptr [NUM_Q];
  int unsigned          fill_count [NUM_Q];
  logic [DEFICIT_W-1:0] deficit [NUM_Q];
  int unsigned          rr_cursor;
  logic [QUANTUM_W-1:0] quantum_cfg [NUM_QUANTUM_REGS];

  // apply one transaction to the shadow and return the decision it yields
  function automatic out_item_t schedule_decision(in_item_t item);
    out_item_t            res;
    int unsigned          q;
    int unsigned          j;
    bit                   done;
    logic [LEN_W-1:0]     plen;
    logic [DEFICIT_W-1:0] need;
    logic [DEFICIT_W:0]   sum;
    res  = '0;
    done = 1'b0;
    if (item.action == ACT_ENQUEUE) begin
      q = item.queue_index;
      if (q >= NUM_Q || fill_count[q] >= DEPTH) begin
        res.enqueue_dropped = 1'b1;
      end else begin
        len_mem[q][wr_ptr[q]] = item.packet_length;
        wr_ptr[q] = (wr_ptr[q] + 1) % DEPTH;
        fill_count[q]++;
      end
    end else begin
      for (j = 0; j < NUM_Q && !done; j++) begin
        q = rr_cursor;
        if (fill_count[q] == 0) begin
          // an empty queue forfeits its credit
          deficit[q] = '0;
        end else begin
          plen = len_mem[q][rd_ptr[q]];
          need = DEFICIT_W'(plen) << FRAC_SHIFT;
          res.backlog_seen = 1'b1;
          if (need <= deficit[q]) begin
            // grant and stay on this queue
            deficit[q] = deficit[q] - need;
            rd_ptr[q] = (rd_ptr[q] + 1) % DEPTH;
            fill_count[q]--;
            res.granted      = 1'b1;
            res.grant_queue  = GQ_W'(q);
            res.grant_length = plen;
            done = 1'b1;
          end
        end
        if (!done) begin
          // move on and credit the next queue, saturating
          rr_cursor = (q + 1) % NUM_Q;
          sum = {1'b0, deficit[rr_cursor]} +
                (DEFICIT_W + 1)'(quantum_cfg[rr_cursor % NUM_QUANTUM_REGS]);
          deficit[rr_cursor] = sum[DEFICIT_W] ? '1 : sum[DEFICIT_W-1:0];
        end
      end
    end
    return res;
  endfunction

  // one decision as text for reports
  function automatic string show(out_item_t r);
    return $sformatf("g=%0d q=%0d len=%0d drop=%0d seen=%0d", r.granted, r.grant_queue,
                     r.grant_length, r.enqueue_dropped, r.backlog_seen);
  endfunction

  function automatic in_item_t make_item(logic act, int unsigned q, int unsigned len);
    in_item_t it;
    it.action        = act;
    it.queue_index   = QIDX_W'(q);
    it.packet_length = LEN_W'(len);
    return it;
  endfunction

  // random transaction: half the lengths are at most 1500 bytes, a tenth are
  // extremes (0 or all ones), the rest span the whole 16-bit range
  function automatic in_item_t random_item(int unsigned deq_pct);
    in_item_t it;
    it.action      = ($urandom_range(99) < deq_pct) ? ACT_DEQUEUE : ACT_ENQUEUE;
    it.queue_index = QIDX_W'($urandom_range(NUM_Q - 1));
    case ($urandom_range(9))
      0:             it.packet_length = $urandom_range(1) ? '1 : '0;
      1, 2, 3, 4, 5: it.packet_length = LEN_W'($urandom_range(1500));
      default:       it.packet_length = LEN_W'($urandom);
    endcase
    return it;
  endfunction

  // driver: offer pending items, hold valid and payload until accepted
  always @(posedge clk_i) begin : drive_items
    bit holding;
    holding = 1'b0;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        owed_decisions.push_back(schedule_decision(in_data_i));
      end
      holding = in_valid_i && !in_ready_o;
      if (!holding) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each decision with the oldest one owed
  always @(posedge clk_i) begin : check_decisions
    out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (owed_decisions.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("%0t: unexpected transaction %s", $realtime, show(out_data_o));
        end else begin
          want = owed_decisions.pop_front();
          if (out_data_o.granted !== want.granted ||
              out_data_o.grant_queue !== want.grant_queue ||
              out_data_o.grant_length !== want.grant_length ||
              out_data_o.enqueue_dropped !== want.enqueue_dropped ||
              out_data_o.backlog_seen !== want.backlog_seen) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
              $display("%0t: mismatch expected %s, got %s", $realtime, show(want),
                       show(out_data_o));
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // program all four quanta back to back, only while the block is idle
  task automatic set_quanta(logic [QUANTUM_W-1:0] v0, logic [QUANTUM_W-1:0] v1,
                            logic [QUANTUM_W-1:0] v2, logic [QUANTUM_W-1:0] v3);
    logic [QUANTUM_W-1:0] vals [NUM_QUANTUM_REGS];
    logic [CFG_IDX_W-1:0] regs [NUM_QUANTUM_REGS];
    vals = '{v0, v1, v2, v3};
    regs = '{REG_QUANTUM_Q0, REG_QUANTUM_Q1, REG_QUANTUM_Q2, REG_QUANTUM_Q3};
    for (int i = 0; i < NUM_QUANTUM_REGS; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      quantum_cfg[regs[i]] = vals[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sampled on the falling edge so the driver and monitor have settled
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || owed_decisions.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_random(int unsigned count, int unsigned send_pct,
                            int unsigned recv_pct, int unsigned deq_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) pending_items.push_back(random_item(deq_pct));
    wait_drained();
  endtask

  initial begin
    // shadow starts at its reset state
    for (int q = 0; q < NUM_Q; q++) begin
      rd_ptr[q]     = 0;
      wr_ptr[q]     = 0;
      fill_count[q] = 0;
      deficit[q]    = '0;
    end
    rr_cursor = 0;
    for (int r = 0; r < NUM_QUANTUM_REGS; r++) quantum_cfg[r] = QUANTUM_RESET;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: dequeue with nothing backlogged
    pending_items.push_back(make_item(ACT_DEQUEUE, 0, 0));
    // zero-length head grants on any credit; 500 bytes fits one default
    // quantum exactly, 501 does not; a 64k packet stays stuck for now
    pending_items.push_back(make_item(ACT_ENQUEUE, 0, 0));
    pending_items.push_back(make_item(ACT_ENQUEUE, 1, 65535));
    pending_items.push_back(make_item(ACT_ENQUEUE, 2, 500));
    pending_items.push_back(make_item(ACT_ENQUEUE, 2, 501));
    repeat (3) pending_items.push_back(make_item(ACT_DEQUEUE, 0, 0));
    // fill queue 3 to the brim, the last one is refused
    for (int i = 0; i <= DEPTH; i++)
      pending_items.push_back(make_item(ACT_ENQUEUE, 3,
                                        i == 0 ? 0 : i == 1 ? 65535 : $urandom));
    wait_drained();

    // mid-range quanta, sender idles less than receiver
    set_quanta(QUANTUM_W'($urandom_range(20000, 400000)),
               QUANTUM_W'($urandom_range(20000, 400000)),
               QUANTUM_W'($urandom_range(20000, 400000)),
               QUANTUM_W'($urandom_range(20000, 400000)));
    run_random(300, 34, 59, 50);

    // extremes: no credit, full credit, a single fraction, default
    set_quanta('0, QUANTUM_MAX, QUANTUM_W'(1), QUANTUM_RESET);
    run_random(300, 59, 34, 50);

    // everything at maximum, no idling from here on
    set_quanta(QUANTUM_MAX, QUANTUM_MAX, QUANTUM_MAX, QUANTUM_MAX);
    run_random(175, 0, 0, 55);

    // fully random quanta
    set_quanta(QUANTUM_W'($urandom), QUANTUM_W'($urandom),
               QUANTUM_W'($urandom), QUANTUM_W'($urandom));
    run_random(175, 0, 0, 50);

    if (mismatch_count == 0 && owed_decisions.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
